// File: rtl/core/sqvs_pkg.sv
// sprite quad vertex setup: shared constants, codes and the quarter-wave sine table
// no dependencies; used by sprite_quad_vertex_setup_top

package sqvs_pkg;

    // quarter-wave table size
    localparam int unsigned SINE_TABLE_BITS = 8;
    localparam int unsigned SINE_M          = 1 << SINE_TABLE_BITS;
    localparam int unsigned SINE_N          = SINE_M + 1;
    localparam int unsigned SINE_AW         = SINE_TABLE_BITS + 1;
    localparam int unsigned SINE_W          = 17;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 24;
    localparam logic [CFG_INDEX_W-1:0] REG_U_SCALE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_V_SCALE = 8'd1;
    localparam logic [CFG_DATA_W-1:0]  SCALE_ONE   = 24'd8388608;

    // angle quadrants
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // corner order
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_BR = 2'd3;

    // output ranges
    localparam logic signed [23:0] POS_MAX = 24'sh7fffff;
    localparam logic signed [23:0] POS_MIN = -24'sh800000;
    localparam logic [16:0]        UV_MAX  = 17'h1ffff;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [SINE_W-1:0] sine_tab_t [SINE_N];

    // sin(i*pi/(2*M)) in Q1.16 from a Q30 integer taylor series
    function automatic logic [SINE_W-1:0] sine_entry(int unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          sum;
        longint          r;
        if (i >= SINE_M) begin
            return 17'd65536;
        end
        x   = (HALF_PI_Q30 * longint'(i)) >> SINE_TABLE_BITS;
        x2  = (x * x) >> 30;
        t   = x;
        sum = longint'(x);
        t   = ((t * x2) >> 30) / 64'd6;
        sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 64'd20;
        sum = sum + longint'(t);
        t   = ((t * x2) >> 30) / 64'd42;
        sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 64'd72;
        sum = sum + longint'(t);
        t   = ((t * x2) >> 30) / 64'd110;
        sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 64'd156;
        sum = sum + longint'(t);
        if (sum < 0) begin
            sum = 0;
        end
        r = (sum + 8192) >>> 14;
        if (r > 65536) begin
            r = 65536;
        end
        return r[SINE_W-1:0];
    endfunction

    function automatic sine_tab_t build_sine_table();
        sine_tab_t tab;
        for (int unsigned k = 0; k < SINE_N; k++) begin
            tab[k] = sine_entry(k);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

// File: rtl/core/sprite_quad_vertex_setup_top.sv
// sprite quad vertex setup top: sprite request in, four corner vertices out
// depends on sqvs_pkg (sine table, register indexes, corner and quadrant codes)
//
// throughput: one vertex per cycle while m_ready allows, set by the single result channel
// a new sprite is accepted as the last corner of the previous one leaves the request register
// pipeline: request register / corner offsets / multipliers / rounding / position add and output
// reset: valid bits clear, u_scale and v_scale return to 1.0 (8388608)

module sprite_quad_vertex_setup_top (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [sqvs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [sqvs_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [19:0]                  s_dest_x,
    input  logic signed [19:0]                  s_dest_y,
    input  logic [17:0]                         s_dest_w,
    input  logic [17:0]                         s_dest_h,
    input  logic signed [19:0]                  s_pivot_x,
    input  logic signed [19:0]                  s_pivot_y,
    input  logic [15:0]                         s_angle,
    input  logic [11:0]                         s_src_x,
    input  logic [11:0]                         s_src_y,
    input  logic [11:0]                         s_src_w,
    input  logic [11:0]                         s_src_h,
    input  logic [1:0]                          s_flip,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_corner,
    output logic signed [23:0]                  m_pos_x,
    output logic signed [23:0]                  m_pos_y,
    output logic [16:0]                         m_tex_u,
    output logic [16:0]                         m_tex_v,
    output logic                                m_last
);

    typedef struct packed {
        logic signed [19:0] dx;
        logic signed [19:0] dy;
        logic [17:0]        dw;
        logic [17:0]        dh;
        logic signed [19:0] px;
        logic signed [19:0] py;
        logic [11:0]        sx;
        logic [11:0]        sy;
        logic [11:0]        sw;
        logic [11:0]        sh;
        logic [1:0]         flip;
        logic signed [17:0] sin;
        logic signed [17:0] cos;
    } item_t;

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [20:0] ox;
        logic signed [20:0] oy;
        logic signed [17:0] sin;
        logic signed [17:0] cos;
        logic signed [19:0] dx;
        logic signed [19:0] dy;
        logic [12:0]        ue;
        logic [12:0]        ve;
    } st1_t;

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [38:0] pxc;
        logic signed [38:0] pys;
        logic signed [38:0] pxs;
        logic signed [38:0] pyc;
        logic signed [19:0] dx;
        logic signed [19:0] dy;
        logic [36:0]        pu;
        logic [36:0]        pv;
    } st2_t;

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [23:0] rx;
        logic signed [23:0] ry;
        logic signed [19:0] dx;
        logic signed [19:0] dy;
        logic [16:0]        u;
        logic [16:0]        v;
    } st3_t;

    localparam logic [sqvs_pkg::SINE_AW-1:0] SINE_M_A = sqvs_pkg::SINE_AW'(sqvs_pkg::SINE_M);

    logic [sqvs_pkg::CFG_DATA_W-1:0] u_scale_reg;
    logic [sqvs_pkg::CFG_DATA_W-1:0] v_scale_reg;

    item_t      item_reg, item_next;
    logic       item_valid_reg;
    logic [1:0] corner_reg;
    st1_t       st1_reg, st1_next;
    logic       st1_valid_reg;
    st2_t       st2_reg, st2_next;
    logic       st2_valid_reg;
    st3_t       st3_reg, st3_next;
    logic       st3_valid_reg;

    logic [1:0]         out_corner_reg;
    logic signed [23:0] out_pos_x_reg, out_pos_x_next;
    logic signed [23:0] out_pos_y_reg, out_pos_y_next;
    logic [16:0]        out_u_reg;
    logic [16:0]        out_v_reg;
    logic               out_valid_reg;

    logic rdy1, rdy2, rdy3, rdy4;
    logic in_xfer;
    logic emit;

    // per-stage ready chain, each stage fills a bubble ahead of it
    assign rdy4    = !out_valid_reg || m_ready;
    assign rdy3    = !st3_valid_reg || rdy4;
    assign rdy2    = !st2_valid_reg || rdy3;
    assign rdy1    = !st1_valid_reg || rdy2;
    assign emit    = item_valid_reg && rdy1;
    assign s_ready = !item_valid_reg || (emit && corner_reg == sqvs_pkg::CORNER_BR);
    assign in_xfer = s_valid && s_ready;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_scale_reg <= sqvs_pkg::SCALE_ONE;
            v_scale_reg <= sqvs_pkg::SCALE_ONE;
        end else if (cfg_wr_en) begin
            if (cfg_index == sqvs_pkg::REG_U_SCALE) begin
                u_scale_reg <= cfg_wdata;
            end
            if (cfg_index == sqvs_pkg::REG_V_SCALE) begin
                v_scale_reg <= cfg_wdata;
            end
        end
    end

    // request register with sine/cosine lookup
    always_comb begin
        logic [sqvs_pkg::SINE_TABLE_BITS-1:0] idx;
        logic [sqvs_pkg::SINE_AW-1:0]         idx_a;
        logic [sqvs_pkg::SINE_AW-1:0]         idx_b;
        logic signed [17:0]                   sa;
        logic signed [17:0]                   sb;
        idx   = s_angle[13 -: sqvs_pkg::SINE_TABLE_BITS];
        idx_a = {1'b0, idx};
        idx_b = SINE_M_A - idx_a;
        sa    = $signed({1'b0, sqvs_pkg::SINE_TABLE[idx_a]});
        sb    = $signed({1'b0, sqvs_pkg::SINE_TABLE[idx_b]});

        item_next.dx   = s_dest_x;
        item_next.dy   = s_dest_y;
        item_next.dw   = s_dest_w;
        item_next.dh   = s_dest_h;
        item_next.px   = s_pivot_x;
        item_next.py   = s_pivot_y;
        item_next.sx   = s_src_x;
        item_next.sy   = s_src_y;
        item_next.sw   = s_src_w;
        item_next.sh   = s_src_h;
        item_next.flip = s_flip;
        unique case (s_angle[15:14])
            sqvs_pkg::QUAD_0: begin
                item_next.sin = sa;
                item_next.cos = sb;
            end
            sqvs_pkg::QUAD_1: begin
                item_next.sin = sb;
                item_next.cos = -sa;
            end
            sqvs_pkg::QUAD_2: begin
                item_next.sin = -sa;
                item_next.cos = -sb;
            end
            sqvs_pkg::QUAD_3: begin
                item_next.sin = -sb;
                item_next.cos = sa;
            end
            default: begin
                item_next.sin = sa;
                item_next.cos = sb;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            corner_reg     <= sqvs_pkg::CORNER_TL;
        end else begin
            if (in_xfer) begin
                item_valid_reg <= 1'b1;
                corner_reg     <= sqvs_pkg::CORNER_TL;
            end else if (emit) begin
                if (corner_reg == sqvs_pkg::CORNER_BR) begin
                    item_valid_reg <= 1'b0;
                end
                corner_reg <= corner_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            item_reg <= item_next;
        end
    end

    // stage 1: corner offset from pivot and flipped texel edges
    always_comb begin
        logic col;
        logic row;
        col = corner_reg[0];
        row = corner_reg[1];
        st1_next.corner = corner_reg;
        st1_next.ox     = (col ? $signed({3'b000, item_reg.dw}) : 21'sd0)
                        - $signed({item_reg.px[19], item_reg.px});
        st1_next.oy     = (row ? $signed({3'b000, item_reg.dh}) : 21'sd0)
                        - $signed({item_reg.py[19], item_reg.py});
        st1_next.sin    = item_reg.sin;
        st1_next.cos    = item_reg.cos;
        st1_next.dx     = item_reg.dx;
        st1_next.dy     = item_reg.dy;
        st1_next.ue     = {1'b0, item_reg.sx}
                        + ((col ^ item_reg.flip[0]) ? {1'b0, item_reg.sw} : 13'd0);
        st1_next.ve     = {1'b0, item_reg.sy}
                        + ((row ^ item_reg.flip[1]) ? {1'b0, item_reg.sh} : 13'd0);
    end

    // stage 2: rotation and texture scale products
    always_comb begin
        st2_next.corner = st1_reg.corner;
        st2_next.pxc    = $signed(st1_reg.ox) * $signed(st1_reg.cos);
        st2_next.pys    = $signed(st1_reg.oy) * $signed(st1_reg.sin);
        st2_next.pxs    = $signed(st1_reg.ox) * $signed(st1_reg.sin);
        st2_next.pyc    = $signed(st1_reg.oy) * $signed(st1_reg.cos);
        st2_next.dx     = st1_reg.dx;
        st2_next.dy     = st1_reg.dy;
        st2_next.pu     = st1_reg.ue * u_scale_reg;
        st2_next.pv     = st1_reg.ve * v_scale_reg;
    end

    // stage 3: round rotated offsets to Q4 (floor after half added), round and clamp uv
    always_comb begin
        logic signed [39:0] sum_x;
        logic signed [39:0] sum_y;
        logic [37:0]        ur;
        logic [37:0]        vr;
        sum_x = $signed({st2_reg.pxc[38], st2_reg.pxc})
              - $signed({st2_reg.pys[38], st2_reg.pys}) + 40'sd32768;
        sum_y = $signed({st2_reg.pxs[38], st2_reg.pxs})
              + $signed({st2_reg.pyc[38], st2_reg.pyc}) + 40'sd32768;
        ur    = {1'b0, st2_reg.pu} + 38'd64;
        vr    = {1'b0, st2_reg.pv} + 38'd64;
        st3_next.corner = st2_reg.corner;
        st3_next.rx     = sum_x[39:16];
        st3_next.ry     = sum_y[39:16];
        st3_next.dx     = st2_reg.dx;
        st3_next.dy     = st2_reg.dy;
        st3_next.u      = (|ur[37:24]) ? sqvs_pkg::UV_MAX : ur[23:7];
        st3_next.v      = (|vr[37:24]) ? sqvs_pkg::UV_MAX : vr[23:7];
    end

    // stage 4: move to dest minus half a pixel, saturate
    always_comb begin
        logic signed [25:0] sx_full;
        logic signed [25:0] sy_full;
        sx_full = $signed({{6{st3_reg.dx[19]}}, st3_reg.dx}) - 26'sd8
                + $signed({{2{st3_reg.rx[23]}}, st3_reg.rx});
        sy_full = $signed({{6{st3_reg.dy[19]}}, st3_reg.dy}) - 26'sd8
                + $signed({{2{st3_reg.ry[23]}}, st3_reg.ry});
        if (sx_full > 26'sd8388607) begin
            out_pos_x_next = sqvs_pkg::POS_MAX;
        end else if (sx_full < -26'sd8388608) begin
            out_pos_x_next = sqvs_pkg::POS_MIN;
        end else begin
            out_pos_x_next = sx_full[23:0];
        end
        if (sy_full > 26'sd8388607) begin
            out_pos_y_next = sqvs_pkg::POS_MAX;
        end else if (sy_full < -26'sd8388608) begin
            out_pos_y_next = sqvs_pkg::POS_MIN;
        end else begin
            out_pos_y_next = sy_full[23:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                st1_valid_reg <= item_valid_reg;
            end
            if (rdy2) begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (rdy3) begin
                st3_valid_reg <= st2_valid_reg;
            end
            if (rdy4) begin
                out_valid_reg <= st3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            st1_reg <= st1_next;
        end
        if (rdy2) begin
            st2_reg <= st2_next;
        end
        if (rdy3) begin
            st3_reg <= st3_next;
        end
        if (rdy4) begin
            out_corner_reg <= st3_reg.corner;
            out_pos_x_reg  <= out_pos_x_next;
            out_pos_y_reg  <= out_pos_y_next;
            out_u_reg      <= st3_reg.u;
            out_v_reg      <= st3_reg.v;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_corner = out_corner_reg;
    assign m_pos_x  = out_pos_x_reg;
    assign m_pos_y  = out_pos_y_reg;
    assign m_tex_u  = out_u_reg;
    assign m_tex_v  = out_v_reg;
    assign m_last   = (out_corner_reg == sqvs_pkg::CORNER_BR);

endmodule
